// ----- hw/rtl/pic_pkg.sv -----
// Shared types and codes for the point-in-circles classifier.
// Depends on nothing; used by pic_cell and the top level.
`default_nettype none

package pic_pkg;

  localparam int RADIUS_W = 19;
  localparam int COUNT_W  = 7;
  localparam int REGION_W = 2;
  localparam int SLOT_W   = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [REGION_W-1:0] REGION_FLUID = 2'd0;
  localparam logic [REGION_W-1:0] REGION_WALL  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_DEEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORT = 2'd1;

  typedef struct packed {
    logic                valid;
    logic [REGION_W-1:0] region;
  } tok_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pic_cell.sv -----
// One cell of the classifier chain: holds one circle and tests a passing point.
// Two pipeline stages per cell. Depends on pic_pkg.
`default_nettype none

module pic_cell #(
  parameter int COORD_BITS = 20
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  adv,
  input  wire                                  active,
  input  wire                                  wr_en,
  input  wire logic signed [COORD_BITS-1:0]    wr_x,
  input  wire logic signed [COORD_BITS-1:0]    wr_y,
  input  wire logic [pic_pkg::RADIUS_W-1:0]    wr_r,
  input  wire logic [pic_pkg::RADIUS_W-1:0]    support,
  input  wire pic_pkg::tok_t                   tok_i,
  input  wire logic signed [COORD_BITS-1:0]    px_i,
  input  wire logic signed [COORD_BITS-1:0]    py_i,
  output pic_pkg::tok_t                        tok_o,
  output logic signed [COORD_BITS-1:0]         px_o,
  output logic signed [COORD_BITS-1:0]         py_o
);
  import pic_pkg::*;

  localparam int DW    = COORD_BITS + 1;
  localparam int CMP_W = (DW > RADIUS_W) ? DW : RADIUS_W;
  localparam int SQ_W  = 2 * RADIUS_W;
  localparam int SUM_W = SQ_W + 1;

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [RADIUS_W-1:0]          r_r;
  logic [SQ_W-1:0]              r_sq_r, inner_sq_r;
  logic                         deep_ok_r;

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        ax, ay;
  logic [CMP_W-1:0]     ax_w, ay_w, r_w;
  logic [RADIUS_W-1:0]  ax_n, ay_n, inner;
  logic                 inbox;

  tok_t                         a_tok_r;
  logic signed [COORD_BITS-1:0] a_px_r, a_py_r;
  logic                         a_inbox_r;
  logic [SQ_W-1:0]              a_sqx_r, a_sqy_r;

  logic [SUM_W-1:0]    dsq;
  logic [REGION_W-1:0] region_nxt;
  tok_t                tok_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cx_r <= wr_x;
      cy_r <= wr_y;
      r_r  <= wr_r;
    end
  end

  assign inner = r_r - support;

  always_ff @(posedge clk) begin
    r_sq_r     <= SQ_W'(r_r) * SQ_W'(r_r);
    inner_sq_r <= SQ_W'(inner) * SQ_W'(inner);
    deep_ok_r  <= (r_r > support);
  end

  always_comb begin
    dx    = DW'(px_i) - DW'(cx_r);
    dy    = DW'(py_i) - DW'(cy_r);
    ax    = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
    ay    = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);
    ax_w  = CMP_W'(ax);
    ay_w  = CMP_W'(ay);
    r_w   = CMP_W'(r_r);
    inbox = (ax_w <= r_w) && (ay_w <= r_w);
    ax_n  = ax_w[RADIUS_W-1:0];
    ay_n  = ay_w[RADIUS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tok_r <= '0;
    end else if (adv) begin
      a_tok_r <= tok_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px_r    <= px_i;
      a_py_r    <= py_i;
      a_inbox_r <= inbox;
      a_sqx_r   <= SQ_W'(ax_n) * SQ_W'(ax_n);
      a_sqy_r   <= SQ_W'(ay_n) * SQ_W'(ay_n);
    end
  end

  always_comb begin
    dsq        = SUM_W'(a_sqx_r) + SUM_W'(a_sqy_r);
    region_nxt = a_tok_r.region;
    if (a_tok_r.region == REGION_FLUID && active && a_inbox_r) begin
      if (deep_ok_r && dsq < SUM_W'(inner_sq_r)) begin
        region_nxt = REGION_DEEP;
      end else if (dsq <= SUM_W'(r_sq_r)) begin
        region_nxt = REGION_WALL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r.valid  <= a_tok_r.valid;
      tok_r.region <= region_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= a_px_r;
      py_r <= a_py_r;
    end
  end

  assign tok_o = tok_r;
  assign px_o  = px_r;
  assign py_o  = py_r;

endmodule

`default_nettype wire

// ----- hw/rtl/point_in_circles_classifier_unit.sv -----
// Top level of the point-in-circles classifier: head register, cell chain, output register.
// Depends on pic_pkg and pic_cell.
//
// Each table entry lives in its own cell of a chain of MAX_CIRCLES cells. A query point
// enters a head register and moves one cell stage per cycle while the chain advances, two
// stages per cell, and leaves through the output register, whatever circle_count is.
// Queries may enter back to back, one per cycle, and the chain stalls only while a finished
// result waits at the output. A load writes its cell in the cycle it is taken and gives no
// result; it is taken only once every query in flight has been delivered, so loads drain
// the chain first. Configuration writes likewise wait for an empty chain. No clearing pass
// follows reset.
`default_nettype none

module point_in_circles_classifier_unit #(
  parameter int MAX_CIRCLES = 64,
  parameter int COORD_BITS  = 20
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_operation,
  input  wire logic [pic_pkg::SLOT_W-1:0]      in_entry_index,
  input  wire logic signed [COORD_BITS-1:0]    in_point_x,
  input  wire logic signed [COORD_BITS-1:0]    in_point_y,
  input  wire logic [pic_pkg::RADIUS_W-1:0]    in_radius,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [pic_pkg::REGION_W-1:0]         out_region,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pic_pkg::RADIUS_W-1:0]    cfg_data
);
  import pic_pkg::*;

  localparam int INFL_MAX = 2 * MAX_CIRCLES + 2;
  localparam int CNT_W    = $clog2(INFL_MAX + 1);

  logic [COUNT_W-1:0]  count_r;
  logic [RADIUS_W-1:0] support_r;

  tok_t                         head_tok_r;
  logic signed [COORD_BITS-1:0] head_px_r, head_py_r;

  tok_t                         tok_c [MAX_CIRCLES+1];
  logic signed [COORD_BITS-1:0] px_c  [MAX_CIRCLES+1];
  logic signed [COORD_BITS-1:0] py_c  [MAX_CIRCLES+1];
  logic [MAX_CIRCLES-1:0]       act;
  logic [MAX_CIRCLES-1:0]       wr_en;

  logic                out_valid_r;
  logic [REGION_W-1:0] out_region_r;
  logic [CNT_W-1:0]    inflight_r, inflight_nxt;

  tok_t tail;
  logic adv, in_xfer, q_xfer, ld_xfer, out_xfer;

  assign tail     = tok_c[MAX_CIRCLES];
  assign adv      = !tail.valid || !out_valid_r || out_ready;
  assign in_ready = (in_operation == OP_QUERY) ? adv : (inflight_r == '0);
  assign in_xfer  = in_valid && in_ready;
  assign q_xfer   = in_xfer && (in_operation == OP_QUERY);
  assign ld_xfer  = in_xfer && (in_operation == OP_LOAD);
  assign out_xfer = out_valid_r && out_ready;
  assign cfg_ready = (inflight_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      support_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COUNT:   count_r   <= cfg_data[COUNT_W-1:0];
        CFG_SUPPORT: support_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_tok_r <= '0;
    end else if (adv) begin
      head_tok_r.valid  <= q_xfer;
      head_tok_r.region <= REGION_FLUID;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head_px_r <= in_point_x;
      head_py_r <= in_point_y;
    end
  end

  assign tok_c[0] = head_tok_r;
  assign px_c[0]  = head_px_r;
  assign py_c[0]  = head_py_r;

  for (genvar i = 0; i < MAX_CIRCLES; i++) begin : g_cell
    assign act[i]   = (int'(count_r) > i);
    assign wr_en[i] = ld_xfer && (int'(in_entry_index) == i);

    pic_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .active  (act[i]),
      .wr_en   (wr_en[i]),
      .wr_x    (in_point_x),
      .wr_y    (in_point_y),
      .wr_r    (in_radius),
      .support (support_r),
      .tok_i   (tok_c[i]),
      .px_i    (px_c[i]),
      .py_i    (py_c[i]),
      .tok_o   (tok_c[i+1]),
      .px_o    (px_c[i+1]),
      .py_o    (py_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_region_r <= tail.region;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_region = out_region_r;

  assign inflight_nxt = inflight_r + CNT_W'(q_xfer) - CNT_W'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_out_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> inflight_r != '0)
    else $error("result shown with no query in flight");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(inflight_r) <= INFL_MAX)
    else $error("in-flight count beyond chain depth");

  a_empty_chain: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == '0 |-> !head_tok_r.valid && !tail.valid && !out_valid_r)
    else $error("query token present while none in flight");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_region_r == REGION_FLUID || out_region_r == REGION_WALL ||
                     out_region_r == REGION_DEEP))
    else $error("undefined region code");

endmodule

`default_nettype wire

// ----- tb/point_in_circles_classifier_unit_test.sv -----
// Self-checking testbench for point_in_circles_classifier_unit: directed table, then random phases.
// Depends on pic_pkg and the classifier RTL; predicts query regions from its own circle table unless a row gives one.
`default_nettype none

module point_in_circles_classifier_unit_test;
  import pic_pkg::*;

  localparam int COORD_W   = 20;
  localparam int N_CIRCLES = 64;
  localparam int LATENCY   = 2 * N_CIRCLES + 2;
  localparam int HOLD_OFF  = 400;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic                     op;
    logic [SLOT_W-1:0]        slot;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic [RADIUS_W-1:0]      r;
    bit                       known;
    logic [REGION_W-1:0]      region;
    logic [CFG_IDX_W-1:0]     cfg_idx;
    logic [RADIUS_W-1:0]      cfg_val;
  } stim_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_operation;
  logic [SLOT_W-1:0]           in_entry_index;
  logic signed [COORD_W-1:0]   in_point_x;
  logic signed [COORD_W-1:0]   in_point_y;
  logic [RADIUS_W-1:0]         in_radius;
  logic                        out_valid;
  logic                        out_ready;
  logic [REGION_W-1:0]         out_region;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [RADIUS_W-1:0]         cfg_data;

  logic signed [COORD_W-1:0]   ctr_x [N_CIRCLES];
  logic signed [COORD_W-1:0]   ctr_y [N_CIRCLES];
  logic [RADIUS_W-1:0]         rad_tab [N_CIRCLES];
  logic [COUNT_W-1:0]          count_shadow;
  logic [RADIUS_W-1:0]         support_shadow;

  logic [REGION_W-1:0]         expected_regions [$];
  stim_row_t                   stim_rows [$];

  int errors;
  int n_loads;
  int n_queries;
  int region_hits [3];
  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;

  point_in_circles_classifier_unit #(
    .MAX_CIRCLES(N_CIRCLES),
    .COORD_BITS (COORD_W)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_entry_index(in_entry_index),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_radius     (in_radius),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_region    (out_region),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [REGION_W-1:0] classify_point(logic signed [COORD_W-1:0] px,
                                                         logic signed [COORD_W-1:0] py);
    longint ax, ay, dsq, r, inner;
    int n;
    n = (count_shadow > N_CIRCLES) ? N_CIRCLES : int'(count_shadow);
    for (int i = 0; i < n; i++) begin
      r  = longint'(rad_tab[i]);
      ax = longint'(px) - longint'(ctr_x[i]);
      ay = longint'(py) - longint'(ctr_y[i]);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (ax > r || ay > r) continue;
      dsq = ax * ax + ay * ay;
      if (r > longint'(support_shadow)) begin
        inner = r - longint'(support_shadow);
        if (dsq < inner * inner) return REGION_DEEP;
      end
      if (dsq <= r * r) return REGION_WALL;
    end
    return REGION_FLUID;
  endfunction

  function automatic stim_row_t row_load(int slot, int x, int y, int r);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: OP_LOAD, slot: slot[SLOT_W-1:0], x: x[COORD_W-1:0],
            y: y[COORD_W-1:0], r: r[RADIUS_W-1:0], known: 1'b0, region: REGION_FLUID,
            cfg_idx: CFG_COUNT, cfg_val: '0};
    return row;
  endfunction

  function automatic stim_row_t row_query(int x, int y, int r, bit known,
                                          logic [REGION_W-1:0] region);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: OP_QUERY, slot: '1, x: x[COORD_W-1:0], y: y[COORD_W-1:0],
            r: r[RADIUS_W-1:0], known: known, region: region, cfg_idx: CFG_COUNT,
            cfg_val: '0};
    return row;
  endfunction

  function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t row;
    row = '{kind: ROW_CFG, op: OP_LOAD, slot: '0, x: '0, y: '0, r: '0, known: 1'b0,
            region: REGION_FLUID, cfg_idx: idx, cfg_val: val[RADIUS_W-1:0]};
    return row;
  endfunction

  function automatic void add_row(stim_row_t row);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic logic [COORD_W-1:0] rand_center();
    if ($urandom_range(0, 1)) return COORD_W'($urandom());
    return COORD_W'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [RADIUS_W-1:0] rand_radius();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return RADIUS_W'($urandom());
    return RADIUS_W'($urandom_range(0, 12000));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y, logic [RADIUS_W-1:0] r, bit known,
                           logic [REGION_W-1:0] region);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_operation   = op;
    in_entry_index = slot;
    in_point_x     = x;
    in_point_y     = y;
    in_radius      = r;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD) begin
      ctr_x[slot]   = x;
      ctr_y[slot]   = y;
      rad_tab[slot] = r;
      n_loads++;
    end else begin
      expected_regions.insert(expected_regions.size(),
                              known ? region : classify_point(x, y));
      n_queries++;
    end
    @(negedge clk);
  endtask

  task automatic random_query();
    int n, j, span, sel;
    logic [COORD_W-1:0] qx, qy;
    n   = (count_shadow > N_CIRCLES) ? N_CIRCLES : int'(count_shadow);
    j   = $urandom_range(0, (n > 0) ? n - 1 : N_CIRCLES - 1);
    sel = $urandom_range(0, 9);
    if (sel <= 6) begin
      span = int'(rad_tab[j]) + int'(rad_tab[j]) / 4 + 2;
      qx = COORD_W'(int'(ctr_x[j]) + int'($urandom_range(0, 2 * span)) - span);
      qy = COORD_W'(int'(ctr_y[j]) + int'($urandom_range(0, 2 * span)) - span);
    end else if (sel == 7) begin
      qx = ctr_x[j];
      qy = ctr_y[j];
    end else begin
      qx = COORD_W'($urandom());
      qy = COORD_W'($urandom());
    end
    send_item(OP_QUERY, SLOT_W'($urandom()), qx, qy, RADIUS_W'($urandom()), 1'b0,
              REGION_FLUID);
  endtask

  task automatic random_load(int slot);
    send_item(OP_LOAD, slot[SLOT_W-1:0], rand_center(), rand_center(), rand_radius(), 1'b0,
              REGION_FLUID);
  endtask

  task automatic run_random(int n_items, int load_pct);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < load_pct) random_load($urandom_range(0, N_CIRCLES - 1));
      else random_query();
    end
  endtask

  // Drain every pending result, then let the pipeline go quiet.
  task automatic settle();
    int guard;
    guard = 0;
    in_valid = 1'b0;
    while (expected_regions.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RADIUS_W-1:0] val);
    settle();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_COUNT) count_shadow = val[COUNT_W-1:0];
    else if (idx == CFG_SUPPORT) support_shadow = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int hold_seen;
    hold_seen = 0;
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_left = HOLD_OFF;
        hold_seen = hold_req;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic [REGION_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (out_region <= REGION_DEEP) region_hits[out_region]++;
      if (expected_regions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual region %0d", $time,
                 out_region);
      end else begin
        want = expected_regions.pop_front();
        if (out_region !== want) begin
          errors++;
          $display("%0t: region mismatch, expected %0d, actual %0d", $time, want,
                   out_region);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_LOAD;
    in_entry_index = '0;
    in_point_x     = '0;
    in_point_y     = '0;
    in_radius      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_COUNT;
    cfg_data       = '0;
    errors         = 0;
    n_loads        = 0;
    n_queries      = 0;
    region_hits    = '{0, 0, 0};
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 0;
    count_shadow   = '0;
    support_shadow = '0;
    for (int i = 0; i < N_CIRCLES; i++) begin
      ctr_x[i]   = '0;
      ctr_y[i]   = '0;
      rad_tab[i] = '0;
    end

    add_row(row_query(0, 0, 0, 1'b1, REGION_FLUID));
    add_row(row_load(0, 0, 0, 0));
    add_row(row_cfg(CFG_COUNT, 1));
    add_row(row_query(0, 0, 0, 1'b1, REGION_WALL));
    add_row(row_query(1, 0, 0, 1'b1, REGION_FLUID));
    add_row(row_query(0, -1, 0, 1'b1, REGION_FLUID));
    add_row(row_load(0, -524288, -524288, 524287));
    add_row(row_load(1, 524287, 524287, 4096));
    add_row(row_cfg(CFG_COUNT, 2));
    add_row(row_query(-524288, -524288, 524287, 1'b1, REGION_DEEP));
    add_row(row_query(524287, 524287, 0, 1'b1, REGION_DEEP));
    add_row(row_query(524287, 520191, 0, 1'b1, REGION_WALL));
    add_row(row_query(524287, 520190, 0, 1'b1, REGION_FLUID));
    add_row(row_query(0, 0, 0, 1'b0, REGION_FLUID));
    add_row(row_load(2, 0, 0, 5));
    add_row(row_load(63, -1, 1, 262144));
    add_row(row_cfg(CFG_COUNT, 3));
    add_row(row_query(3, 4, 0, 1'b0, REGION_FLUID));
    add_row(row_query(3, 3, 0, 1'b0, REGION_FLUID));
    add_row(row_query(-4, -3, 0, 1'b0, REGION_FLUID));
    add_row(row_cfg(CFG_SUPPORT, 524287));
    add_row(row_query(-524288, -524288, 0, 1'b1, REGION_WALL));
    add_row(row_query(524287, 524287, 0, 1'b1, REGION_WALL));
    add_row(row_cfg(CFG_SUPPORT, 1));
    add_row(row_query(3, 3, 0, 1'b0, REGION_FLUID));
    add_row(row_query(2, 2, 0, 1'b0, REGION_FLUID));
    add_row(row_cfg(CFG_SUPPORT, 5));
    add_row(row_query(0, 0, 0, 1'b0, REGION_FLUID));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[k]) begin
      if (stim_rows[k].kind == ROW_CFG) begin
        write_reg(stim_rows[k].cfg_idx, stim_rows[k].cfg_val);
      end else begin
        send_item(stim_rows[k].op, stim_rows[k].slot, stim_rows[k].x, stim_rows[k].y,
                  stim_rows[k].r, stim_rows[k].known, stim_rows[k].region);
      end
    end

    for (int s = 0; s < N_CIRCLES; s++) begin
      random_load(s);
      if ($urandom_range(0, 1)) random_query();
    end
    run_random(40, 10);

    write_reg(CFG_COUNT, RADIUS_W'({RADIUS_W'($urandom_range(0, 4095)) << COUNT_W} |
                                   N_CIRCLES));
    write_reg(CFG_SUPPORT, RADIUS_W'(0));
    idle_pct = 66;
    run_random(80, 15);

    write_reg(CFG_COUNT, RADIUS_W'(127));
    write_reg(CFG_SUPPORT, RADIUS_W'(524287));
    idle_pct  = 0;
    stall_pct = 66;
    run_random(80, 15);

    write_reg(CFG_COUNT, RADIUS_W'(1));
    write_reg(CFG_SUPPORT, RADIUS_W'($urandom_range(0, 8192)));
    idle_pct  = 19;
    stall_pct = 19;
    run_random(80, 15);

    // hold the output off while queries keep coming, so the chain backs up
    write_reg(CFG_COUNT, RADIUS_W'($urandom_range(2, N_CIRCLES - 1)));
    write_reg(CFG_SUPPORT, RADIUS_W'($urandom_range(0, 4096)));
    idle_pct  = 0;
    stall_pct = 19;
    hold_req++;
    run_random(150, 0);

    write_reg(CFG_COUNT, RADIUS_W'(0));
    write_reg(CFG_SUPPORT, RADIUS_W'($urandom_range(0, 524287)));
    idle_pct = 19;
    run_random(30, 20);

    settle();
    if (expected_regions.size() != 0) begin
      errors += expected_regions.size();
      $display("%0t: %0d expected results never arrived", $time, expected_regions.size());
    end

    $display("Run covered %0d loads and %0d queries: %0d fluid, %0d wall, %0d deep.",
             n_loads, n_queries, region_hits[0], region_hits[1], region_hits[2]);
    $display("Counts 0..127 with saturation, support 0..max, %0d-cycle output hold-off.",
             HOLD_OFF);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/pic_pkg.sv
hw/rtl/pic_cell.sv
hw/rtl/point_in_circles_classifier_unit.sv
tb/point_in_circles_classifier_unit_test.sv
